@@ rtl/scd_pkg.sv @@
`timescale 1ns / 1ps

package scd_pkg;

    localparam logic [7:0] SC_PREFIX    = 8'hE0;
    localparam logic [7:0] SC_REL_MASK  = 8'h80;
    localparam logic [7:0] SC_CODE_MASK = 8'h7F;

    localparam logic [6:0] SC_LSHIFT = 7'h2A;
    localparam logic [6:0] SC_RSHIFT = 7'h36;
    localparam logic [6:0] SC_CTRL   = 7'h1D;
    localparam logic [6:0] SC_ALT    = 7'h38;

    localparam logic [6:0] SC_EXT_UP    = 7'h48;
    localparam logic [6:0] SC_EXT_DOWN  = 7'h50;
    localparam logic [6:0] SC_EXT_LEFT  = 7'h4B;
    localparam logic [6:0] SC_EXT_RIGHT = 7'h4D;

    localparam logic [2:0] MSK_NONE  = 3'b000;
    localparam logic [2:0] MSK_SHIFT = 3'b001;
    localparam logic [2:0] MSK_CTRL  = 3'b010;
    localparam logic [2:0] MSK_ALT   = 3'b100;

    localparam logic [4:0] KC_A     = 5'd0;
    localparam logic [4:0] KC_B     = 5'd1;
    localparam logic [4:0] KC_C     = 5'd2;
    localparam logic [4:0] KC_F1    = 5'd3;
    localparam logic [4:0] KC_F2    = 5'd4;
    localparam logic [4:0] KC_F3    = 5'd5;
    localparam logic [4:0] KC_F4    = 5'd6;
    localparam logic [4:0] KC_F5    = 5'd7;
    localparam logic [4:0] KC_F6    = 5'd8;
    localparam logic [4:0] KC_F7    = 5'd9;
    localparam logic [4:0] KC_F8    = 5'd10;
    localparam logic [4:0] KC_F9    = 5'd11;
    localparam logic [4:0] KC_F10   = 5'd12;
    localparam logic [4:0] KC_F11   = 5'd13;
    localparam logic [4:0] KC_F12   = 5'd14;
    localparam logic [4:0] KC_RETURN = 5'd15;
    localparam logic [4:0] KC_SPC   = 5'd16;
    localparam logic [4:0] KC_BKSP  = 5'd17;
    localparam logic [4:0] KC_UP    = 5'd18;
    localparam logic [4:0] KC_DN    = 5'd19;
    localparam logic [4:0] KC_LT    = 5'd20;
    localparam logic [4:0] KC_RT    = 5'd21;

    typedef struct packed {
        logic [4:0] code;
        logic       released;
        logic [2:0] mods;
    } t_event;

    typedef struct packed {
        logic       prefix;
        logic       push;
        logic [4:0] code;
        logic       released;
        logic [2:0] mod_bit;
    } t_dec;

endpackage

@@ rtl/scd_decode.sv @@
`timescale 1ns / 1ps

module scd_decode (
    input  logic [7:0]  i_byte,
    input  logic        i_ext,
    output scd_pkg::t_dec o_dec
);

    logic [6:0] sc;
    logic       rel;
    logic       plain_hit;
    logic [4:0] plain_code;
    logic       ext_hit;
    logic [4:0] ext_code;
    logic [2:0] mod_bit;

    assign sc  = 7'(i_byte & scd_pkg::SC_CODE_MASK);
    assign rel = (i_byte & scd_pkg::SC_REL_MASK) != 8'h00;

    always_comb begin
        plain_hit  = 1'b1;
        plain_code = scd_pkg::KC_A;
        case (sc)
            7'h1E: plain_code = scd_pkg::KC_A;
            7'h30: plain_code = scd_pkg::KC_B;
            7'h2E: plain_code = scd_pkg::KC_C;
            7'h3B: plain_code = scd_pkg::KC_F1;
            7'h3C: plain_code = scd_pkg::KC_F2;
            7'h3D: plain_code = scd_pkg::KC_F3;
            7'h3E: plain_code = scd_pkg::KC_F4;
            7'h3F: plain_code = scd_pkg::KC_F5;
            7'h40: plain_code = scd_pkg::KC_F6;
            7'h41: plain_code = scd_pkg::KC_F7;
            7'h42: plain_code = scd_pkg::KC_F8;
            7'h43: plain_code = scd_pkg::KC_F9;
            7'h44: plain_code = scd_pkg::KC_F10;
            7'h57: plain_code = scd_pkg::KC_F11;
            7'h58: plain_code = scd_pkg::KC_F12;
            7'h1C: plain_code = scd_pkg::KC_RETURN;
            7'h39: plain_code = scd_pkg::KC_SPC;
            7'h0E: plain_code = scd_pkg::KC_BKSP;
            default: plain_hit = 1'b0;
        endcase
    end

    always_comb begin
        ext_hit  = 1'b1;
        ext_code = scd_pkg::KC_UP;
        case (sc)
            scd_pkg::SC_EXT_UP:    ext_code = scd_pkg::KC_UP;
            scd_pkg::SC_EXT_DOWN:  ext_code = scd_pkg::KC_DN;
            scd_pkg::SC_EXT_LEFT:  ext_code = scd_pkg::KC_LT;
            scd_pkg::SC_EXT_RIGHT: ext_code = scd_pkg::KC_RT;
            default: ext_hit = 1'b0;
        endcase
    end

    always_comb begin
        case (sc)
            scd_pkg::SC_LSHIFT, scd_pkg::SC_RSHIFT: mod_bit = scd_pkg::MSK_SHIFT;
            scd_pkg::SC_CTRL:                       mod_bit = scd_pkg::MSK_CTRL;
            scd_pkg::SC_ALT:                        mod_bit = scd_pkg::MSK_ALT;
            default:                                mod_bit = scd_pkg::MSK_NONE;
        endcase
    end

    // Extended bytes never touch modifiers; fake shifts after the prefix drop.
    always_comb begin
        o_dec          = '0;
        o_dec.released = rel;
        if (i_byte == scd_pkg::SC_PREFIX) begin
            o_dec.prefix = 1'b1;
        end else if (i_ext) begin
            o_dec.push = ext_hit;
            o_dec.code = ext_code;
        end else begin
            o_dec.mod_bit = mod_bit;
            o_dec.push    = plain_hit && (mod_bit == scd_pkg::MSK_NONE);
            o_dec.code    = plain_code;
        end
    end

endmodule

@@ rtl/scd_event_ring.sv @@
`timescale 1ns / 1ps

module scd_event_ring #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  scd_pkg::t_event i_wr_data,
    input  logic            i_pop,
    output logic            o_pop_hit,
    output scd_pkg::t_event o_rd_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    scd_pkg::t_event r_mem [FIFO_DEPTH];
    scd_pkg::t_event r_rd_data;
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [PTR_W-1:0] n_wp, n_rp;
    logic [PTR_W-1:0] wp_inc, rp_inc;
    logic             full;
    logic             push_ok;

    assign wp_inc    = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
    assign rp_inc    = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
    assign full      = (wp_inc == r_rp);
    assign push_ok   = i_push && !full;
    assign o_pop_hit = i_pop && (r_wp != r_rp);
    assign n_wp      = push_ok ? wp_inc : r_wp;
    assign n_rp      = o_pop_hit ? rp_inc : r_rp;
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_wr_data;
        end
        if (o_pop_hit) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    // the ring never holds more than depth-1 beats
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (full && i_push && !i_pop) |=> (r_wp == $past(r_wp)))
        else $error("push taken into a full ring");

endmodule

@@ rtl/scancode_event_decoder_fifo.sv @@
`timescale 1ns / 1ps

// Channel  | Direction | Handshake       | Payload
// ---------+-----------+-----------------+-------------------------------------------
// request  | in        | start / busy    | i_req_type, i_scan_byte
// result   | out       | o_done strobe   | o_event_valid, o_key_code, o_key_released,
//          |           |                 | o_event_modifiers, o_current_modifiers
//
// One beat is taken every cycle; busy stays low.
// Each result strobes o_done after its request beat passes the input
// register, then decode, ring update and the registered ring read.
// The event ring is FIFO_DEPTH entries of on-chip memory with one write
// and one registered read port; it holds FIFO_DEPTH-1 events.
// Reset clears the pointers, modifier mask and prefix flag; no sweep.
// The receiver cannot stall: each result is valid for exactly one cycle.

module scancode_event_decoder_fifo #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_req_type,
    input  logic [7:0] i_scan_byte,
    output logic       o_done,
    output logic       o_event_valid,
    output logic [4:0] o_key_code,
    output logic       o_key_released,
    output logic [2:0] o_event_modifiers,
    output logic [2:0] o_current_modifiers
);

    logic       r_in_valid;
    logic       r_req;
    logic [7:0] r_byte;
    logic       r_ext, n_ext;
    logic [2:0] r_mods, n_mods;
    logic       r_done;
    logic       r_hit;

    scd_pkg::t_dec   dec;
    scd_pkg::t_event wr_data;
    scd_pkg::t_event rd_data;
    logic            is_byte;
    logic            pop;
    logic            pop_hit;

    assign busy = 1'b0;

    scd_decode u_decode (
        .i_byte (r_byte),
        .i_ext  (r_ext),
        .o_dec  (dec)
    );

    assign is_byte = r_in_valid && !r_req;
    assign pop     = r_in_valid && r_req;

    assign wr_data.code     = dec.code;
    assign wr_data.released = dec.released;
    assign wr_data.mods     = r_mods;

    scd_event_ring #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (is_byte && dec.push),
        .i_wr_data (wr_data),
        .i_pop     (pop),
        .o_pop_hit (pop_hit),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_ext  = r_ext;
        n_mods = r_mods;
        if (is_byte) begin
            n_ext = dec.prefix;
            if (dec.released) begin
                n_mods = r_mods & ~dec.mod_bit;
            end else begin
                n_mods = r_mods | dec.mod_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_ext      <= 1'b0;
            r_mods     <= '0;
            r_done     <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
            r_ext      <= n_ext;
            r_mods     <= n_mods;
            r_done     <= r_in_valid;
            r_hit      <= pop_hit;
        end
    end

    // hold the request payload with the beat
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req  <= i_req_type;
            r_byte <= i_scan_byte;
        end
    end

    assign o_done              = r_done;
    assign o_event_valid       = r_hit;
    assign o_key_code          = r_hit ? rd_data.code : '0;
    assign o_key_released      = r_hit && rd_data.released;
    assign o_event_modifiers   = r_hit ? rd_data.mods : '0;
    assign o_current_modifiers = r_mods;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event_valid |-> o_done)
        else $error("event returned without a result strobe");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_mods == $past(r_mods)))
        else $error("pop changed the modifier mask");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_byte && r_ext) |=> (r_mods == $past(r_mods)))
        else $error("extended byte changed the modifier mask");

endmodule
